### rtl/time_literal_parser_macros.svh
// Assertion macros for the time literal parser.
// Included by the top level; no other dependencies.
`ifndef TIME_LITERAL_PARSER_MACROS_SVH
`define TIME_LITERAL_PARSER_MACROS_SVH
`ifndef SYNTH
`define TLP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("time_literal_parser: same-cycle check failed");
`define TLP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("time_literal_parser: next-cycle check failed");
`else
`define TLP_ASSERT_IMP(label, clk, rst, ante, cons)
`define TLP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/tlp_pkg.sv
// Shared types and constants of the time literal parser.
// No dependencies.
package tlp_pkg;

   localparam int CNT_W = 10;
   localparam logic [CNT_W-1:0] LENGTH_LIMIT = 10'd1023;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic [2:0] SEL_NS  = 3'd0;
   localparam logic [2:0] SEL_US  = 3'd1;
   localparam logic [2:0] SEL_MS  = 3'd2;
   localparam logic [2:0] SEL_S   = 3'd3;
   localparam logic [2:0] SEL_MIN = 3'd4;
   localparam logic [2:0] SEL_H   = 3'd5;
   localparam logic [2:0] SEL_D   = 3'd6;

   typedef enum logic [3:0] {
      PH_START, PH_NUM_WS, PH_NUM_SIGN, PH_NUM_DIG,
      PH_T, PH_TI, PH_TIM, PH_HASH,
      PH_SEG_FIRST, PH_SEG, PH_SEG_WS, PH_SEG_SIGN,
      PH_SEG_DIG, PH_AFTER_M, PH_AFTER_UN, PH_DONE
   } phase_type;

   // One queued command: up to two scaled terms, an overwrite, or the end of a literal.
   typedef struct packed {
      logic             add0_en;
      logic [63:0]      add0_val;
      logic [2:0]       add0_sel;
      logic             add1_en;
      logic [63:0]      add1_val;
      logic [2:0]       add1_sel;
      logic             set_en;
      logic [63:0]      set_val;
      logic             last;
      logic             err;
      logic [CNT_W-1:0] count;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic [63:0] factor(logic [2:0] sel);
      logic [63:0] f;
      case (sel)
         SEL_US:  f = 64'd1000;
         SEL_MS:  f = 64'd1000000;
         SEL_S:   f = 64'd1000000000;
         SEL_MIN: f = 64'd60000000000;
         SEL_H:   f = 64'd3600000000000;
         SEL_D:   f = 64'd86400000000000;
         default: f = 64'd1;
      endcase
      return f;
   endfunction

endpackage

### rtl/tlp_req_if.sv
// Request channel of the time literal parser: one character per transfer.
// No dependencies.
interface tlp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       is_last;

   modport source (output valid, char_code, is_last, input ready);
   modport sink (input valid, char_code, is_last, output ready);
endinterface

### rtl/tlp_rsp_if.sv
// Response channel of the time literal parser: one parsed duration per transfer.
// No dependencies.
interface tlp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] duration_ns;
   logic [9:0]         chars_used;
   logic               parse_error;

   modport source (output valid, duration_ns, chars_used, parse_error, input ready);
   modport sink (input valid, duration_ns, chars_used, parse_error, output ready);
endinterface

### rtl/tlp_front.sv
// Character classifier and parse state machine; emits scale-and-add commands.
// Depends on tlp_pkg and tlp_req_if.
module tlp_front (
   input  logic                   clock,
   input  logic                   reset,
   tlp_req_if.sink                req_if,
   input  tlp_pkg::q_status_type  q_status,
   output logic                   q_push,
   output tlp_pkg::entry_type     q_entry
);

   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_D     = 8'h64;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CH_H     = 8'h68;
   localparam logic [7:0] CH_I     = 8'h69;
   localparam logic [7:0] CH_M     = 8'h6D;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_S     = 8'h73;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_U     = 8'h75;

   tlp_pkg::phase_type            phase_ff, phase_in;
   logic [63:0]                   num_ff, num_in;
   logic                          neg_ff, neg_in;
   logic                          dig_ff, dig_in;
   logic [tlp_pkg::CNT_W-1:0]     pre_ff, pre_in;
   logic [2:0]                    sel_ff, sel_in;
   logic [tlp_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic                          err_ff, err_in;

   logic                          accept;
   logic [7:0]                    c;
   logic [7:0]                    lc;
   logic                          is_sp, is_dg, is_sg;
   logic                          run_num, run_seg, unit_hit;
   logic [2:0]                    usel;
   tlp_pkg::entry_type            entry;

   function automatic logic [tlp_pkg::CNT_W-1:0] sat_add(
      logic [tlp_pkg::CNT_W-1:0] a, logic [tlp_pkg::CNT_W-1:0] b);
      logic [tlp_pkg::CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, tlp_pkg::LENGTH_LIMIT}) ? tlp_pkg::LENGTH_LIMIT
                                                 : s[tlp_pkg::CNT_W-1:0];
   endfunction

   // Magnitude times ten plus the digit, clamped at the signed limit.
   function automatic logic [63:0] next_digit(logic [63:0] n, logic neg, logic [7:0] ch);
      logic [67:0] wide;
      logic [67:0] lim;
      wide = ({4'b0, n} << 3) + ({4'b0, n} << 1) + {64'b0, ch[3:0]};
      lim  = neg ? {4'b0, 64'h8000_0000_0000_0000} : {4'b0, 64'h7FFF_FFFF_FFFF_FFFF};
      return (wide > lim) ? lim[63:0] : wide[63:0];
   endfunction

   function automatic logic [63:0] seg_value(logic [63:0] n, logic neg);
      return neg ? (64'd0 - n) : n;
   endfunction

   function automatic tlp_pkg::entry_type push_term(
      tlp_pkg::entry_type e, logic [63:0] v, logic [2:0] s);
      tlp_pkg::entry_type r;
      r = e;
      if (!r.add0_en) begin
         r.add0_en  = 1'b1;
         r.add0_val = v;
         r.add0_sel = s;
      end else begin
         r.add1_en  = 1'b1;
         r.add1_val = v;
         r.add1_sel = s;
      end
      return r;
   endfunction

   assign req_if.ready = !q_status.full;
   assign accept       = req_if.valid && req_if.ready;
   assign c            = req_if.char_code;
   assign lc           = (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
   assign is_sp        = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
   assign is_dg        = (c >= CH_ZERO) && (c <= CH_NINE);
   assign is_sg        = (c == CH_PLUS) || (c == CH_MINUS);

   always_comb begin
      phase_in = phase_ff;
      num_in   = num_ff;
      neg_in   = neg_ff;
      dig_in   = dig_ff;
      pre_in   = pre_ff;
      sel_in   = sel_ff;
      cnt_in   = cnt_ff;
      err_in   = err_ff;
      entry    = '0;
      run_num  = 1'b0;
      run_seg  = 1'b0;
      unit_hit = 1'b0;
      usel     = sel_ff;

      if (accept) begin
         unique case (phase_ff)
            tlp_pkg::PH_START: begin
               if (lc == CH_T) begin
                  cnt_in   = 10'd1;
                  phase_in = tlp_pkg::PH_T;
               end else begin
                  run_num = 1'b1;
               end
            end
            tlp_pkg::PH_NUM_WS, tlp_pkg::PH_NUM_SIGN, tlp_pkg::PH_NUM_DIG: begin
               run_num = 1'b1;
            end
            tlp_pkg::PH_T: begin
               cnt_in = sat_add(cnt_ff, 10'd1);
               if (c == CH_HASH) begin
                  phase_in = tlp_pkg::PH_SEG_FIRST;
               end else if (lc == CH_I) begin
                  phase_in = tlp_pkg::PH_TI;
               end else begin
                  err_in   = 1'b1;
                  phase_in = tlp_pkg::PH_DONE;
               end
            end
            tlp_pkg::PH_TI: begin
               cnt_in = sat_add(cnt_ff, 10'd1);
               if (lc == CH_M) begin
                  phase_in = tlp_pkg::PH_TIM;
               end else begin
                  err_in   = 1'b1;
                  phase_in = tlp_pkg::PH_DONE;
               end
            end
            tlp_pkg::PH_TIM: begin
               cnt_in = sat_add(cnt_ff, 10'd1);
               if (lc == CH_E) begin
                  phase_in = tlp_pkg::PH_HASH;
               end else begin
                  err_in   = 1'b1;
                  phase_in = tlp_pkg::PH_DONE;
               end
            end
            tlp_pkg::PH_HASH: begin
               cnt_in = sat_add(cnt_ff, 10'd1);
               if (c == CH_HASH) begin
                  phase_in = tlp_pkg::PH_SEG_FIRST;
               end else begin
                  err_in   = 1'b1;
                  phase_in = tlp_pkg::PH_DONE;
               end
            end
            tlp_pkg::PH_AFTER_M: begin
               // "ms" or minutes followed by something else
               if (lc == CH_S) begin
                  cnt_in = sat_add(cnt_ff, 10'd1);
                  sel_in = tlp_pkg::SEL_MS;
               end else begin
                  sel_in  = tlp_pkg::SEL_MIN;
                  run_seg = 1'b1;
               end
               entry    = push_term(entry, seg_value(num_ff, neg_ff), sel_in);
               num_in   = 64'd0;
               neg_in   = 1'b0;
               dig_in   = 1'b0;
               pre_in   = '0;
               phase_in = tlp_pkg::PH_SEG;
            end
            tlp_pkg::PH_AFTER_UN: begin
               phase_in = tlp_pkg::PH_SEG;
               if (lc == CH_S) begin
                  cnt_in = sat_add(cnt_ff, 10'd1);
               end else begin
                  run_seg = 1'b1;
               end
            end
            tlp_pkg::PH_DONE: begin
            end
            tlp_pkg::PH_SEG_FIRST, tlp_pkg::PH_SEG, tlp_pkg::PH_SEG_WS,
            tlp_pkg::PH_SEG_SIGN, tlp_pkg::PH_SEG_DIG: begin
               run_seg = 1'b1;
            end
         endcase

         // plain decimal number
         if (run_num) begin
            if (phase_in != tlp_pkg::PH_NUM_SIGN && phase_in != tlp_pkg::PH_NUM_DIG
                && is_sp) begin
               pre_in   = sat_add(pre_in, 10'd1);
               phase_in = tlp_pkg::PH_NUM_WS;
            end else if (phase_in != tlp_pkg::PH_NUM_SIGN
                         && phase_in != tlp_pkg::PH_NUM_DIG && is_sg) begin
               neg_in   = (c == CH_MINUS);
               pre_in   = sat_add(pre_in, 10'd1);
               phase_in = tlp_pkg::PH_NUM_SIGN;
            end else if (is_dg) begin
               num_in   = next_digit(num_in, neg_in, c);
               dig_in   = 1'b1;
               pre_in   = sat_add(pre_in, 10'd1);
               phase_in = tlp_pkg::PH_NUM_DIG;
            end else begin
               if (phase_in == tlp_pkg::PH_NUM_DIG) begin
                  entry.set_en  = 1'b1;
                  entry.set_val = seg_value(num_in, neg_in);
                  cnt_in        = pre_in;
               end
               phase_in = tlp_pkg::PH_DONE;
            end
         end

         // segment character, falling through to the unit decoder
         if (run_seg) begin
            if ((phase_in == tlp_pkg::PH_SEG_FIRST || phase_in == tlp_pkg::PH_SEG
                 || phase_in == tlp_pkg::PH_SEG_WS) && is_sp) begin
               pre_in   = sat_add(pre_in, 10'd1);
               phase_in = tlp_pkg::PH_SEG_WS;
            end else if ((phase_in == tlp_pkg::PH_SEG_FIRST || phase_in == tlp_pkg::PH_SEG
                          || phase_in == tlp_pkg::PH_SEG_WS) && is_sg) begin
               neg_in   = (c == CH_MINUS);
               pre_in   = sat_add(pre_in, 10'd1);
               phase_in = tlp_pkg::PH_SEG_SIGN;
            end else if (is_dg) begin
               num_in   = next_digit(num_in, neg_in, c);
               dig_in   = 1'b1;
               pre_in   = sat_add(pre_in, 10'd1);
               phase_in = tlp_pkg::PH_SEG_DIG;
            end else if (phase_in == tlp_pkg::PH_SEG_WS || phase_in == tlp_pkg::PH_SEG_SIGN) begin
               err_in   = 1'b1;
               phase_in = tlp_pkg::PH_DONE;
            end else begin
               unique case (lc)
                  CH_D: begin
                     unit_hit = 1'b1;
                     usel     = tlp_pkg::SEL_D;
                  end
                  CH_H: begin
                     unit_hit = 1'b1;
                     usel     = tlp_pkg::SEL_H;
                  end
                  CH_S: begin
                     unit_hit = 1'b1;
                     usel     = tlp_pkg::SEL_S;
                  end
                  CH_U: begin
                     unit_hit = 1'b1;
                     usel     = tlp_pkg::SEL_US;
                  end
                  CH_N: begin
                     unit_hit = 1'b1;
                     usel     = tlp_pkg::SEL_NS;
                  end
                  CH_UNDER: begin
                     unit_hit = 1'b1;
                     usel     = sel_in;
                  end
                  CH_M: begin
                     cnt_in   = sat_add(cnt_in, sat_add(pre_in, 10'd1));
                     phase_in = tlp_pkg::PH_AFTER_M;
                  end
                  default: begin
                     if (!dig_in) begin
                        err_in   = 1'b1;
                        phase_in = tlp_pkg::PH_DONE;
                     end else begin
                        // trailing number without unit: scale by the current factor
                        cnt_in   = sat_add(cnt_in, pre_in);
                        entry    = push_term(entry, seg_value(num_in, neg_in), sel_in);
                        phase_in = tlp_pkg::PH_DONE;
                     end
                  end
               endcase
               if (unit_hit) begin
                  cnt_in   = sat_add(cnt_in, sat_add(pre_in, 10'd1));
                  sel_in   = usel;
                  entry    = push_term(entry, seg_value(num_in, neg_in), usel);
                  num_in   = 64'd0;
                  neg_in   = 1'b0;
                  dig_in   = 1'b0;
                  pre_in   = '0;
                  phase_in = (lc == CH_U || lc == CH_N) ? tlp_pkg::PH_AFTER_UN
                                                          : tlp_pkg::PH_SEG;
               end
            end
         end

         // end of literal: close the open item, emit, and drop back to reset state
         if (req_if.is_last) begin
            unique case (phase_in)
               tlp_pkg::PH_NUM_WS, tlp_pkg::PH_NUM_SIGN: begin
                  entry.set_en  = 1'b1;
                  entry.set_val = 64'd0;
                  cnt_in        = '0;
               end
               tlp_pkg::PH_NUM_DIG: begin
                  entry.set_en  = 1'b1;
                  entry.set_val = seg_value(num_in, neg_in);
                  cnt_in        = pre_in;
               end
               tlp_pkg::PH_SEG_DIG: begin
                  cnt_in = sat_add(cnt_in, pre_in);
                  entry  = push_term(entry, seg_value(num_in, neg_in), sel_in);
               end
               tlp_pkg::PH_AFTER_M: begin
                  entry = push_term(entry, seg_value(num_in, neg_in), tlp_pkg::SEL_MIN);
               end
               tlp_pkg::PH_SEG, tlp_pkg::PH_AFTER_UN, tlp_pkg::PH_DONE: begin
               end
               default: begin
                  err_in = 1'b1;
               end
            endcase
            entry.last  = 1'b1;
            entry.err   = err_in;
            entry.count = cnt_in;
            phase_in    = tlp_pkg::PH_START;
            num_in      = 64'd0;
            neg_in      = 1'b0;
            dig_in      = 1'b0;
            pre_in      = '0;
            sel_in      = tlp_pkg::SEL_NS;
            cnt_in      = '0;
            err_in      = 1'b0;
         end
      end
   end

   assign q_entry = entry;
   assign q_push  = accept && (entry.add0_en || entry.add1_en || entry.set_en || entry.last);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tlp_pkg::PH_START;
         num_ff   <= 64'd0;
         neg_ff   <= 1'b0;
         dig_ff   <= 1'b0;
         pre_ff   <= '0;
         sel_ff   <= tlp_pkg::SEL_NS;
         cnt_ff   <= '0;
         err_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         num_ff   <= num_in;
         neg_ff   <= neg_in;
         dig_ff   <= dig_in;
         pre_ff   <= pre_in;
         sel_ff   <= sel_in;
         cnt_ff   <= cnt_in;
         err_ff   <= err_in;
      end
   end

endmodule

### rtl/tlp_queue.sv
// Short command queue between the parse front end and the arithmetic back end.
// Depends on tlp_pkg.
module tlp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tlp_pkg::entry_type    wr_data,
   input  logic                  pop,
   output tlp_pkg::entry_type    rd_data,
   output tlp_pkg::q_status_type status
);

   tlp_pkg::entry_type              slots_ff [tlp_pkg::Q_DEPTH];
   logic [tlp_pkg::Q_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [tlp_pkg::Q_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [tlp_pkg::Q_CNT_W-1:0]     count_ff, count_in;
   logic                            do_push, do_pop;

   assign status.full  = (count_ff == tlp_pkg::Q_CNT_W'(tlp_pkg::Q_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign rd_data      = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == tlp_pkg::Q_PTR_W'(tlp_pkg::Q_DEPTH - 1)) ? '0
                                                                            : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == tlp_pkg::Q_PTR_W'(tlp_pkg::Q_DEPTH - 1)) ? '0
                                                                            : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/tlp_back.sv
// Scale-and-accumulate back end: split multiplies, term sum, running total, result register.
// Depends on tlp_pkg and tlp_rsp_if.
module tlp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  tlp_pkg::entry_type    q_head,
   input  tlp_pkg::q_status_type q_status,
   output logic                  q_pop,
   tlp_rsp_if.source             rsp_if
);

   typedef struct packed {
      logic                      en;
      logic [63:0]               ll;
      logic [31:0]               lh;
      logic [31:0]               hl;
   } prod_type;

   typedef struct packed {
      prod_type                  p0;
      prod_type                  p1;
      logic                      set_en;
      logic [63:0]               set_val;
      logic                      last;
      logic                      err;
      logic [tlp_pkg::CNT_W-1:0] count;
   } s1_type;

   typedef struct packed {
      logic [63:0]               t0;
      logic [63:0]               t1;
      logic                      set_en;
      logic [63:0]               set_val;
      logic                      last;
      logic                      err;
      logic [tlp_pkg::CNT_W-1:0] count;
   } s2_type;

   logic                       advance;
   logic                       s1_valid_ff, s1_valid_in;
   logic                       s2_valid_ff, s2_valid_in;
   s1_type                     s1_ff, s1_in;
   s2_type                     s2_ff, s2_in;
   logic [63:0]                total_ff, total_in;
   logic [63:0]                sum;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [63:0]                dur_ff, dur_in;
   logic [tlp_pkg::CNT_W-1:0]  used_ff, used_in;
   logic                       perr_ff, perr_in;

   // Low 64 bits of value times factor as three 32x32 partial products.
   function automatic prod_type split_mul(logic en, logic [63:0] v, logic [2:0] sel);
      prod_type    p;
      logic [63:0] f;
      logic [63:0] lh_full;
      logic [63:0] hl_full;
      f       = tlp_pkg::factor(sel);
      lh_full = {32'b0, v[31:0]} * {32'b0, f[63:32]};
      hl_full = {32'b0, v[63:32]} * {32'b0, f[31:0]};
      p.en    = en;
      p.ll    = {32'b0, v[31:0]} * {32'b0, f[31:0]};
      p.lh    = lh_full[31:0];
      p.hl    = hl_full[31:0];
      return p;
   endfunction

   function automatic logic [63:0] join_prod(prod_type p);
      return p.en ? (p.ll + {p.lh + p.hl, 32'b0}) : 64'd0;
   endfunction

   // Whole pipeline advances whenever the result slot is free or being taken.
   assign advance = !rsp_valid_ff || rsp_if.ready;
   assign q_pop   = advance && !q_status.empty;

   always_comb begin
      s1_in.p0      = split_mul(q_head.add0_en, q_head.add0_val, q_head.add0_sel);
      s1_in.p1      = split_mul(q_head.add1_en, q_head.add1_val, q_head.add1_sel);
      s1_in.set_en  = q_head.set_en;
      s1_in.set_val = q_head.set_val;
      s1_in.last    = q_head.last;
      s1_in.err     = q_head.err;
      s1_in.count   = q_head.count;

      s2_in.t0      = join_prod(s1_ff.p0);
      s2_in.t1      = join_prod(s1_ff.p1);
      s2_in.set_en  = s1_ff.set_en;
      s2_in.set_val = s1_ff.set_val;
      s2_in.last    = s1_ff.last;
      s2_in.err     = s1_ff.err;
      s2_in.count   = s1_ff.count;

      s1_valid_in = advance ? !q_status.empty : s1_valid_ff;
      s2_valid_in = advance ? s1_valid_ff : s2_valid_ff;

      sum          = s2_ff.set_en ? s2_ff.set_val : total_ff + s2_ff.t0 + s2_ff.t1;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff;
      dur_in       = dur_ff;
      used_in      = used_ff;
      perr_in      = perr_ff;
      if (advance) begin
         rsp_valid_in = 1'b0;
         if (s2_valid_ff) begin
            total_in = sum;
            if (s2_ff.last) begin
               total_in     = 64'd0;
               rsp_valid_in = 1'b1;
               dur_in       = s2_ff.err ? 64'd0 : sum;
               used_in      = s2_ff.err ? '0 : s2_ff.count;
               perr_in      = s2_ff.err;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
      dur_ff  <= dur_in;
      used_ff <= used_in;
      perr_ff <= perr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         total_ff     <= 64'd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.duration_ns = $signed(dur_ff);
   assign rsp_if.chars_used  = used_ff;
   assign rsp_if.parse_error = perr_ff;

endmodule

### rtl/time_literal_parser.sv
// Top level of the duration literal parser.
// Depends on tlp_pkg, tlp_req_if, tlp_rsp_if, tlp_front, tlp_queue, tlp_back and the macros header.

// Parses a duration literal fed one character per request, either a plain decimal
// nanosecond count or "T[ime]#" followed by signed segments with units d, h, m, ms,
// us, ns and s (any case; an underscore reuses the previous unit). The request
// carrying is_last produces exactly one response with the total in nanoseconds
// (wrapping two's complement), the number of characters consumed (saturating at
// 1023) and a parse error flag; on error the other two fields read zero. The block
// takes one character every clock cycle while the command queue is not full, back
// to back, across literal boundaries. The last character's command passes through
// the queue and the back end, which splits each unit scaling into 32x32 partial
// products, combines them, and then adds them into the running total before the
// response is registered. A four-entry command queue sits between the parse state
// machine and the back end, so a stalled response side holds off new characters only
// once that queue fills.
`include "time_literal_parser_macros.svh"

module time_literal_parser (
   input  logic       clock,
   input  logic       reset,
   tlp_req_if.sink    req_if,
   tlp_rsp_if.source  rsp_if
);

   // commands from the parse state machine into the queue
   logic                  q_push;
   tlp_pkg::entry_type    q_entry;

   // queue head and status toward the back end
   logic                  q_pop;
   tlp_pkg::entry_type    q_head;
   tlp_pkg::q_status_type q_status;

   // Front end: classify each character, advance the parse, and emit scale-and-add
   // commands plus an end-of-literal marker.
   tlp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .q_status (q_status),
      .q_push   (q_push),
      .q_entry  (q_entry)
   );

   // Hold commands so the front end keeps running while the back end stalls.
   tlp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_entry),
      .pop     (q_pop),
      .rd_data (q_head),
      .status  (q_status)
   );

   // Back end: multiply by the unit factor, accumulate, and register the result.
   tlp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_head   (q_head),
      .q_status (q_status),
      .q_pop    (q_pop),
      .rsp_if   (rsp_if)
   );

   // A malformed literal must report zero duration and zero characters.
   `TLP_ASSERT_IMP(a_err_zero, clock, reset, rsp_if.valid && rsp_if.parse_error, rsp_if.duration_ns == 64'sd0 && rsp_if.chars_used == 10'd0)
   // The character count never passes the length limit.
   `TLP_ASSERT_IMP(a_used_limit, clock, reset, rsp_if.valid, rsp_if.chars_used <= tlp_pkg::LENGTH_LIMIT)
   // An overwrite of the total (plain number) never travels with scaled terms.
   `TLP_ASSERT_IMP(a_set_alone, clock, reset, q_push && q_entry.set_en, !q_entry.add0_en && !q_entry.add1_en)
   // A full queue blocks the request side on the next cycle unless a command left.
   `TLP_ASSERT_NEXT(a_full_blocks, clock, reset, q_status.full && !q_pop, !req_if.ready)

endmodule
